>>> hdl/cfsp_pkg.sv
`default_nettype none
package cfsp_pkg;

    typedef enum logic [16:0] {
        PH_MAGIC    = 17'b00000000000000001,
        PH_VERSION  = 17'b00000000000000010,
        PH_POOLCNT  = 17'b00000000000000100,
        PH_TAG      = 17'b00000000000001000,
        PH_CONST    = 17'b00000000000010000,
        PH_UTF8     = 17'b00000000000100000,
        PH_CLASS    = 17'b00000000001000000,
        PH_IFCNT    = 17'b00000000010000000,
        PH_IF       = 17'b00000000100000000,
        PH_FLDCNT   = 17'b00000001000000000,
        PH_FLD      = 17'b00000010000000000,
        PH_METHCNT  = 17'b00000100000000000,
        PH_METH     = 17'b00001000000000000,
        PH_ATTRCNT  = 17'b00010000000000000,
        PH_ATTRHDR  = 17'b00100000000000000,
        PH_ATTRBYTE = 17'b01000000000000000,
        PH_DONE     = 17'b10000000000000000
    } t_phase;

    localparam logic [7:0] TAG_UTF8       = 8'd1;
    localparam logic [7:0] TAG_INTEGER    = 8'd3;
    localparam logic [7:0] TAG_FLOAT      = 8'd4;
    localparam logic [7:0] TAG_LONG       = 8'd5;
    localparam logic [7:0] TAG_DOUBLE     = 8'd6;
    localparam logic [7:0] TAG_CLASS      = 8'd7;
    localparam logic [7:0] TAG_STRING     = 8'd8;
    localparam logic [7:0] TAG_FIELDREF   = 8'd9;
    localparam logic [7:0] TAG_METHODREF  = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE   = 8'd12;

    localparam logic [4:0] K_MAGIC     = 5'd0;
    localparam logic [4:0] K_VERSION   = 5'd1;
    localparam logic [4:0] K_POOLCNT   = 5'd2;
    localparam logic [4:0] K_CONST     = 5'd3;
    localparam logic [4:0] K_UTF8      = 5'd4;
    localparam logic [4:0] K_CLASS     = 5'd5;
    localparam logic [4:0] K_IFCNT     = 5'd6;
    localparam logic [4:0] K_IF        = 5'd7;
    localparam logic [4:0] K_FLDCNT    = 5'd8;
    localparam logic [4:0] K_FLD       = 5'd9;
    localparam logic [4:0] K_METHCNT   = 5'd10;
    localparam logic [4:0] K_METH      = 5'd11;
    localparam logic [4:0] K_ATTRCNT   = 5'd12;
    localparam logic [4:0] K_ATTRHDR   = 5'd13;
    localparam logic [4:0] K_ATTRBYTE  = 5'd14;
    localparam logic [4:0] K_ERROR     = 5'd17;

    localparam logic [1:0] SC_FIELD  = 2'd0;
    localparam logic [1:0] SC_METHOD = 2'd1;
    localparam logic [1:0] SC_CLASS  = 2'd2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] entry_index;
        logic [7:0]  tag;
        logic [63:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [1:0]  scope;
        logic        final_record;
    } t_rec;

    function automatic logic [3:0] const_len(input logic [7:0] t);
        case (t) inside
            TAG_CLASS, TAG_STRING, TAG_UTF8: const_len = 4'd2;
            TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE,
            TAG_INTEGER, TAG_FLOAT: const_len = 4'd4;
            TAG_LONG, TAG_DOUBLE: const_len = 4'd8;
            default: const_len = 4'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> hdl/class_file_stream_parser_unit.sv
// class file stream parser
// s_axis carries the class file one byte per transfer (tdata[7:0]).
// m_axis gives one record per completed field but a valid tag: tdata holds
// entry_index, tag, value_a, value_b, value_c, scope; tuser holds kind;
// tlast is final_record (last record of the file, or an unknown tag).
// each byte is decoded combinationally against the parser state and the
// record, if any, goes into an output register backed by one skid entry.
// throughput is one byte per cycle while s_axis_tready is high; a record
// goes to the output register, or to the skid entry while m_axis stalls.
// s_axis_tready drops only while both the output register and skid entry
// are full, so a stalled receiver holds back the input after two records.
// after reset the parser waits for the magic number; after the last record
// or an error every further byte is accepted and dropped.
`default_nettype none
module class_file_stream_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // entry_index[15:0], tag[23:16], value_a[87:24], value_b[103:88],
    // value_c[119:104], scope[121:120], zero fill
    output logic [127:0]     m_axis_tdata,
    output logic [4:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // final_record
);
    import cfsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_pidx, n_pidx, r_ptot, n_ptot;
    logic [15:0] r_lidx, n_lidx, r_ltot, n_ltot;
    logic [15:0] r_aidx, n_aidx, r_atot, n_atot;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_tag, n_tag;
    logic [15:0] r_first, n_first, r_second, n_second;
    logic [1:0]  r_scope, n_scope;

    logic        acc_in, emit, skid_ready;
    t_rec        rec, orec;
    logic [3:0]  need;
    logic [63:0] v;
    logic        done;
    logic [16:0] pnext, lnext, anext;
    logic [31:0] left_dec;
    logic        wide;
    logic        fin;

    assign s_axis_tready = skid_ready;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (r_phase)
            PH_MAGIC, PH_VERSION: need = 4'd4;
            PH_CONST: need = const_len(r_tag);
            PH_CLASS, PH_FLD, PH_METH, PH_ATTRHDR: need = 4'd6;
            PH_POOLCNT, PH_IFCNT, PH_IF, PH_FLDCNT, PH_METHCNT, PH_ATTRCNT:
                need = 4'd2;
            default: need = 4'd1;
        endcase
    end

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_acc = r_acc;
        n_pidx = r_pidx; n_ptot = r_ptot; n_lidx = r_lidx; n_ltot = r_ltot;
        n_aidx = r_aidx; n_atot = r_atot; n_left = r_left; n_tag = r_tag;
        n_first = r_first; n_second = r_second; n_scope = r_scope;
        emit = 1'b0;
        rec = '0;
        v = {r_acc[55:0], s_axis_tdata};
        done = ({1'b0, r_cnt} + 4'd1) >= need;
        wide = (r_tag == TAG_LONG) || (r_tag == TAG_DOUBLE);
        pnext = {1'b0, r_pidx} + (wide ? 17'd2 : 17'd1);
        lnext = {1'b0, r_lidx} + 17'd1;
        anext = {1'b0, r_aidx} + 17'd1;
        left_dec = r_left - 32'd1;
        fin = 1'b0;
        if (acc_in && r_phase != PH_DONE) begin
            if (!done) begin
                n_acc = v;
                n_cnt = r_cnt + 3'd1;
            end else begin
                n_acc = '0;
                n_cnt = '0;
                emit = 1'b1;
                case (r_phase)
                    PH_MAGIC: begin
                        rec.kind = K_MAGIC;
                        rec.value_a = {32'd0, v[31:0]};
                        n_phase = PH_VERSION;
                    end
                    PH_VERSION: begin
                        rec.kind = K_VERSION;
                        rec.value_a = {48'd0, v[15:0]};
                        rec.value_b = v[31:16];
                        n_phase = PH_POOLCNT;
                    end
                    PH_POOLCNT: begin
                        rec.kind = K_POOLCNT;
                        rec.value_a = {48'd0, v[15:0]};
                        n_ptot = v[15:0];
                        n_pidx = 16'd1;
                        n_phase = (v[15:0] <= 16'd1) ? PH_CLASS : PH_TAG;
                    end
                    PH_TAG: begin
                        if (const_len(s_axis_tdata) == 4'd0) begin
                            rec.kind = K_ERROR;
                            rec.entry_index = r_pidx;
                            rec.tag = s_axis_tdata;
                            rec.final_record = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            emit = 1'b0;
                            n_tag = s_axis_tdata;
                            n_phase = PH_CONST;
                        end
                    end
                    PH_CONST: begin
                        rec.kind = K_CONST;
                        rec.entry_index = r_pidx;
                        rec.tag = r_tag;
                        if (r_tag == TAG_UTF8) begin
                            rec.value_a = {48'd0, v[15:0]};
                            n_first = v[15:0];
                            n_left = {16'd0, v[15:0]};
                        end else if (r_tag == TAG_CLASS || r_tag == TAG_STRING) begin
                            rec.value_a = {48'd0, v[15:0]};
                        end else if (r_tag == TAG_INTEGER || r_tag == TAG_FLOAT) begin
                            rec.value_a = {32'd0, v[31:0]};
                        end else if (wide) begin
                            rec.value_a = v;
                        end else begin
                            rec.value_a = {48'd0, v[31:16]};
                            rec.value_b = v[15:0];
                        end
                        if (r_tag == TAG_UTF8 && v[15:0] != 16'd0) begin
                            n_phase = PH_UTF8;
                        end else begin
                            n_pidx = pnext[15:0];
                            n_phase = (pnext >= {1'b0, r_ptot}) ? PH_CLASS : PH_TAG;
                        end
                    end
                    PH_UTF8: begin
                        rec.kind = K_UTF8;
                        rec.entry_index = r_pidx;
                        rec.value_a = {56'd0, s_axis_tdata};
                        rec.value_b = r_first - r_left[15:0];
                        n_left = {16'd0, left_dec[15:0]};
                        if (left_dec[15:0] == 16'd0) begin
                            n_pidx = pnext[15:0];
                            n_phase = (pnext >= {1'b0, r_ptot}) ? PH_CLASS : PH_TAG;
                        end
                    end
                    PH_CLASS: begin
                        rec.kind = K_CLASS;
                        rec.value_a = {48'd0, v[47:32]};
                        rec.value_b = v[31:16];
                        rec.value_c = v[15:0];
                        n_phase = PH_IFCNT;
                    end
                    PH_IFCNT, PH_FLDCNT, PH_METHCNT: begin
                        rec.kind = (r_phase == PH_IFCNT) ? K_IFCNT :
                                   (r_phase == PH_FLDCNT) ? K_FLDCNT : K_METHCNT;
                        rec.value_a = {48'd0, v[15:0]};
                        n_ltot = v[15:0];
                        n_lidx = '0;
                        if (r_phase == PH_IFCNT) begin
                            n_phase = (v[15:0] != 16'd0) ? PH_IF : PH_FLDCNT;
                        end else if (r_phase == PH_FLDCNT) begin
                            n_phase = (v[15:0] != 16'd0) ? PH_FLD : PH_METHCNT;
                        end else if (v[15:0] != 16'd0) begin
                            n_phase = PH_METH;
                        end else begin
                            n_scope = SC_CLASS;
                            n_phase = PH_ATTRCNT;
                        end
                    end
                    PH_IF: begin
                        rec.kind = K_IF;
                        rec.entry_index = r_lidx;
                        rec.value_a = {48'd0, v[15:0]};
                        n_lidx = lnext[15:0];
                        if (lnext[15:0] >= r_ltot) n_phase = PH_FLDCNT;
                    end
                    PH_FLD, PH_METH: begin
                        rec.kind = (r_phase == PH_FLD) ? K_FLD : K_METH;
                        rec.entry_index = r_lidx;
                        rec.value_a = {48'd0, v[47:32]};
                        rec.value_b = v[31:16];
                        rec.value_c = v[15:0];
                        n_scope = (r_phase == PH_FLD) ? SC_FIELD : SC_METHOD;
                        n_phase = PH_ATTRCNT;
                    end
                    PH_ATTRCNT, PH_ATTRHDR, PH_ATTRBYTE: begin
                        // attribute list handling shares the end-of-list step
                        logic list_end;
                        logic [1:0] sc;
                        list_end = 1'b0;
                        sc = (r_scope > SC_CLASS) ? SC_CLASS : r_scope;
                        rec.scope = sc;
                        if (r_phase == PH_ATTRCNT) begin
                            rec.kind = K_ATTRCNT;
                            rec.entry_index = (sc == SC_CLASS) ? 16'd0 : r_lidx;
                            rec.value_a = {48'd0, v[15:0]};
                            n_atot = v[15:0];
                            n_aidx = '0;
                            n_scope = sc;
                            if (v[15:0] == 16'd0) list_end = 1'b1;
                            else n_phase = PH_ATTRHDR;
                        end else if (r_phase == PH_ATTRHDR) begin
                            rec.kind = K_ATTRHDR;
                            rec.entry_index = r_aidx;
                            rec.value_a = {32'd0, v[31:0]};
                            rec.value_b = v[47:32];
                            n_second = v[47:32];
                            n_left = v[31:0];
                            if (v[31:0] == 32'd0) begin
                                n_aidx = anext[15:0];
                                if (anext[15:0] < r_atot) n_phase = PH_ATTRHDR;
                                else list_end = 1'b1;
                            end else begin
                                n_phase = PH_ATTRBYTE;
                            end
                        end else begin
                            rec.kind = K_ATTRBYTE;
                            rec.entry_index = r_aidx;
                            rec.value_a = {56'd0, s_axis_tdata};
                            rec.value_b = r_second;
                            n_left = left_dec;
                            if (left_dec == 32'd0) begin
                                n_aidx = anext[15:0];
                                if (anext[15:0] < r_atot) n_phase = PH_ATTRHDR;
                                else list_end = 1'b1;
                            end
                        end
                        if (list_end) begin
                            if (sc == SC_FIELD) begin
                                n_lidx = lnext[15:0];
                                n_phase = (lnext[15:0] < r_ltot) ? PH_FLD : PH_METHCNT;
                            end else if (sc == SC_METHOD) begin
                                n_lidx = lnext[15:0];
                                if (lnext[15:0] < r_ltot) begin
                                    n_phase = PH_METH;
                                end else begin
                                    n_scope = SC_CLASS;
                                    n_phase = PH_ATTRCNT;
                                end
                            end else begin
                                fin = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end
                        rec.final_record = fin;
                    end
                    default: begin
                        emit = 1'b0;
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_cnt <= '0; r_acc <= '0;
            r_pidx <= 16'd1; r_ptot <= '0; r_lidx <= '0; r_ltot <= '0;
            r_aidx <= '0; r_atot <= '0; r_left <= '0; r_tag <= '0;
            r_first <= '0; r_second <= '0; r_scope <= '0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_acc <= n_acc;
            r_pidx <= n_pidx; r_ptot <= n_ptot; r_lidx <= n_lidx; r_ltot <= n_ltot;
            r_aidx <= n_aidx; r_atot <= n_atot; r_left <= n_left; r_tag <= n_tag;
            r_first <= n_first; r_second <= n_second; r_scope <= n_scope;
        end
    end

    cfsp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (emit),
        .o_ready (skid_ready),
        .i_rec   (rec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (orec)
    );

    assign m_axis_tdata = {6'd0, orec.scope, orec.value_c, orec.value_b, orec.value_a,
                           orec.tag, orec.entry_index};
    assign m_axis_tuser = orec.kind;
    assign m_axis_tlast = orec.final_record;

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("parser left the done phase");
    a_no_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !emit)
        else $error("record emitted after end");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && rec.final_record) |=> (r_phase == PH_DONE))
        else $error("final record without halt");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} < need) || (r_phase == PH_DONE))
        else $error("byte count past field width");
endmodule
`default_nettype wire

>>> hdl/cfsp_skid.sv
`default_nettype none
module cfsp_skid (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cfsp_pkg::t_rec  i_rec,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output cfsp_pkg::t_rec       o_rec
);
    import cfsp_pkg::*;

    // output register plus one skid entry
    logic r_ovalid, r_svalid;
    t_rec r_orec, r_srec;

    assign o_ready = !r_svalid;
    assign o_valid = r_ovalid;
    assign o_rec   = r_orec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else begin
            if (!r_ovalid || i_ready) begin
                if (r_svalid) begin
                    r_ovalid <= 1'b1;
                    r_svalid <= 1'b0;
                end else begin
                    r_ovalid <= i_valid;
                end
            end else if (i_valid) begin
                r_svalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ovalid || i_ready) begin
            r_orec <= r_svalid ? r_srec : i_rec;
        end else if (i_valid && !r_svalid) begin
            r_srec <= i_rec;
        end
    end
endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    import cfsp_pkg::*;

    localparam int POOL_SIZE   = 180;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // byte_in
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // entry_index, tag, value_a, value_b, value_c, scope, zero fill
    logic [127:0] m_axis_tdata;
    logic [4:0]   m_axis_tuser;   // kind
    logic         m_axis_tlast;   // final_record

    class_file_stream_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // parser state mirrored for prediction
    t_phase      prs_phase;
    int          prs_count;
    logic [63:0] prs_shift;
    logic [15:0] prs_pool_idx, prs_pool_total, prs_list_idx, prs_list_total;
    logic [15:0] prs_attr_idx, prs_attr_total, prs_utf8_len, prs_attr_name;
    logic [31:0] prs_left;
    logic [7:0]  prs_tag;
    logic [1:0]  prs_owner;
    logic        prs_halted;

    t_rec pending_recs[$];
    int   fail_count;
    int   bytes_sent;
    int   recs_seen;
    int   cycle_count;
    int   burst_left;
    int   rx_mode;
    int   rx_hold;
    int   tb_pool_idx;

    function automatic int tag_bytes(input logic [7:0] t);
        case (t)
            TAG_UTF8, TAG_CLASS, TAG_STRING: return 2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IMETHODREF, TAG_NAMETYPE: return 4;
            TAG_LONG, TAG_DOUBLE: return 8;
            default: return 0;
        endcase
    endfunction

    task automatic add_rec(input logic [4:0] kind, input logic [15:0] idx,
                           input logic [7:0] tag, input logic [63:0] a,
                           input logic [15:0] b, input logic [15:0] c,
                           input logic [1:0] sc, input logic fin);
        t_rec r;
        r.kind = kind; r.entry_index = idx; r.tag = tag; r.value_a = a;
        r.value_b = b; r.value_c = c; r.scope = sc; r.final_record = fin;
        pending_recs.insert(pending_recs.size(), r);
    endtask

    task automatic pool_next();
        logic [16:0] nxt;
        nxt = {1'b0, prs_pool_idx} +
              ((prs_tag == TAG_LONG || prs_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
        prs_pool_idx = nxt[15:0];
        prs_phase = (nxt >= {1'b0, prs_pool_total}) ? PH_CLASS : PH_TAG;
    endtask

    function automatic logic owner_done();
        if (prs_owner == SC_FIELD) begin
            prs_list_idx = prs_list_idx + 16'd1;
            prs_phase = (prs_list_idx < prs_list_total) ? PH_FLD : PH_METHCNT;
            return 1'b0;
        end
        if (prs_owner == SC_METHOD) begin
            prs_list_idx = prs_list_idx + 16'd1;
            if (prs_list_idx < prs_list_total) begin
                prs_phase = PH_METH;
            end else begin
                prs_owner = SC_CLASS;
                prs_phase = PH_ATTRCNT;
            end
            return 1'b0;
        end
        prs_halted = 1'b1;
        prs_phase = PH_DONE;
        return 1'b1;
    endfunction

    function automatic logic next_attr();
        prs_attr_idx = prs_attr_idx + 16'd1;
        if (prs_attr_idx < prs_attr_total) begin
            prs_phase = PH_ATTRHDR;
            return 1'b0;
        end
        return owner_done();
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        int          need;
        logic [63:0] v;
        logic [15:0] idx;
        logic        fin;
        if (prs_halted || prs_phase == PH_DONE) return;
        case (prs_phase)
            PH_MAGIC, PH_VERSION: need = 4;
            PH_POOLCNT, PH_IFCNT, PH_IF, PH_FLDCNT, PH_METHCNT, PH_ATTRCNT: need = 2;
            PH_CONST: need = tag_bytes(prs_tag);
            PH_CLASS, PH_FLD, PH_METH, PH_ATTRHDR: need = 6;
            default: need = 1;
        endcase
        prs_shift = {prs_shift[55:0], b};
        if (prs_count + 1 < need) begin
            prs_count++;
            return;
        end
        prs_count = 0;
        v = prs_shift;
        prs_shift = '0;
        case (prs_phase)
            PH_MAGIC: begin
                add_rec(K_MAGIC, 0, 0, {32'd0, v[31:0]}, 0, 0, 0, 0);
                prs_phase = PH_VERSION;
            end
            PH_VERSION: begin
                add_rec(K_VERSION, 0, 0, {48'd0, v[15:0]}, v[31:16], 0, 0, 0);
                prs_phase = PH_POOLCNT;
            end
            PH_POOLCNT: begin
                prs_pool_total = v[15:0];
                prs_pool_idx = 16'd1;
                add_rec(K_POOLCNT, 0, 0, {48'd0, v[15:0]}, 0, 0, 0, 0);
                prs_phase = (prs_pool_total <= 16'd1) ? PH_CLASS : PH_TAG;
            end
            PH_TAG: begin
                if (tag_bytes(b) == 0) begin
                    add_rec(K_ERROR, prs_pool_idx, b, 0, 0, 0, 0, 1);
                    prs_halted = 1'b1;
                    prs_phase = PH_DONE;
                end else begin
                    prs_tag = b;
                    prs_phase = PH_CONST;
                end
            end
            PH_CONST: begin
                case (prs_tag)
                    TAG_UTF8: begin
                        prs_utf8_len = v[15:0];
                        prs_left = {16'd0, v[15:0]};
                        add_rec(K_CONST, prs_pool_idx, prs_tag, {48'd0, v[15:0]}, 0, 0, 0, 0);
                        if (prs_left == 0) pool_next();
                        else prs_phase = PH_UTF8;
                    end
                    TAG_CLASS, TAG_STRING: begin
                        add_rec(K_CONST, prs_pool_idx, prs_tag, {48'd0, v[15:0]}, 0, 0, 0, 0);
                        pool_next();
                    end
                    TAG_INTEGER, TAG_FLOAT: begin
                        add_rec(K_CONST, prs_pool_idx, prs_tag, {32'd0, v[31:0]}, 0, 0, 0, 0);
                        pool_next();
                    end
                    TAG_LONG, TAG_DOUBLE: begin
                        add_rec(K_CONST, prs_pool_idx, prs_tag, v, 0, 0, 0, 0);
                        pool_next();
                    end
                    default: begin
                        add_rec(K_CONST, prs_pool_idx, prs_tag, {48'd0, v[31:16]},
                                v[15:0], 0, 0, 0);
                        pool_next();
                    end
                endcase
            end
            PH_UTF8: begin
                add_rec(K_UTF8, prs_pool_idx, 0, {56'd0, b}, prs_utf8_len - prs_left[15:0],
                        0, 0, 0);
                prs_left = {16'd0, prs_left[15:0] - 16'd1};
                if (prs_left == 0) pool_next();
            end
            PH_CLASS: begin
                add_rec(K_CLASS, 0, 0, {48'd0, v[47:32]}, v[31:16], v[15:0], 0, 0);
                prs_phase = PH_IFCNT;
            end
            PH_IFCNT, PH_FLDCNT, PH_METHCNT: begin
                prs_list_total = v[15:0];
                prs_list_idx = 16'd0;
                add_rec(prs_phase == PH_IFCNT ? K_IFCNT :
                        (prs_phase == PH_FLDCNT ? K_FLDCNT : K_METHCNT),
                        0, 0, {48'd0, v[15:0]}, 0, 0, 0, 0);
                if (prs_phase == PH_IFCNT) begin
                    prs_phase = (prs_list_total != 0) ? PH_IF : PH_FLDCNT;
                end else if (prs_phase == PH_FLDCNT) begin
                    prs_phase = (prs_list_total != 0) ? PH_FLD : PH_METHCNT;
                end else if (prs_list_total != 0) begin
                    prs_phase = PH_METH;
                end else begin
                    prs_owner = SC_CLASS;
                    prs_phase = PH_ATTRCNT;
                end
            end
            PH_IF: begin
                add_rec(K_IF, prs_list_idx, 0, {48'd0, v[15:0]}, 0, 0, 0, 0);
                prs_list_idx = prs_list_idx + 16'd1;
                if (prs_list_idx >= prs_list_total) prs_phase = PH_FLDCNT;
            end
            PH_FLD, PH_METH: begin
                add_rec(prs_phase == PH_FLD ? K_FLD : K_METH, prs_list_idx, 0,
                        {48'd0, v[47:32]}, v[31:16], v[15:0], 0, 0);
                prs_owner = (prs_phase == PH_FLD) ? SC_FIELD : SC_METHOD;
                prs_phase = PH_ATTRCNT;
            end
            PH_ATTRCNT: begin
                prs_attr_total = v[15:0];
                prs_attr_idx = 16'd0;
                if (prs_owner > SC_CLASS) prs_owner = SC_CLASS;
                idx = (prs_owner == SC_CLASS) ? 16'd0 : prs_list_idx;
                begin
                    logic [1:0] sc;
                    sc = prs_owner;
                    if (prs_attr_total == 0) begin
                        fin = owner_done();
                    end else begin
                        fin = 1'b0;
                        prs_phase = PH_ATTRHDR;
                    end
                    add_rec(K_ATTRCNT, idx, 0, {48'd0, v[15:0]}, 0, 0, sc, fin);
                end
            end
            PH_ATTRHDR: begin
                prs_attr_name = v[47:32];
                prs_left = v[31:0];
                idx = prs_attr_idx;
                begin
                    logic [1:0] sc;
                    sc = prs_owner;
                    if (prs_left == 0) begin
                        fin = next_attr();
                    end else begin
                        fin = 1'b0;
                        prs_phase = PH_ATTRBYTE;
                    end
                    add_rec(K_ATTRHDR, idx, 0, {32'd0, v[31:0]}, prs_attr_name, 0, sc, fin);
                end
            end
            PH_ATTRBYTE: begin
                idx = prs_attr_idx;
                begin
                    logic [1:0] sc;
                    sc = prs_owner;
                    prs_left = prs_left - 32'd1;
                    fin = (prs_left == 0) ? next_attr() : 1'b0;
                    add_rec(K_ATTRBYTE, idx, 0, {56'd0, b}, prs_attr_name, 0, sc, fin);
                end
            end
            default: prs_halted = 1'b1;
        endcase
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_u16(input logic [15:0] v);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
    endtask

    task automatic send_u32(input logic [31:0] v);
        send_u16(v[31:16]);
        send_u16(v[15:0]);
    endtask

    task automatic send_rand(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    task automatic send_const(input logic [7:0] tag, input int utf8_len);
        send_byte(tag);
        if (tag == TAG_UTF8) begin
            send_u16(16'(utf8_len));
            send_rand(utf8_len);
        end else begin
            send_rand(tag_bytes(tag));
        end
        tb_pool_idx += (tag == TAG_LONG || tag == TAG_DOUBLE) ? 2 : 1;
    endtask

    task automatic send_attrs(input int count, input int max_len);
        int len;
        send_u16(16'(count));
        repeat (count) begin
            len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
            send_u16(16'($urandom));
            send_u32(32'(len));
            send_rand(len);
        end
    endtask

    task automatic test_header();
        send_u32(32'hCAFEBABE);
        send_u16(16'hFFFF);   // minor
        send_u16(16'h0000);   // major
        send_u16(16'(POOL_SIZE));
        tb_pool_idx = 1;
    endtask

    // every tag at least once (UTF8 twice), mostly with extreme contents
    task automatic test_pool_directed();
        send_byte(TAG_UTF8); send_u16(16'd0);
        send_byte(TAG_UTF8); send_u16(16'd3);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
        tb_pool_idx += 2;
        send_byte(TAG_INTEGER); send_u32(32'hFFFFFFFF);
        send_byte(TAG_FLOAT); send_u32(32'h00000000);
        send_byte(TAG_LONG); send_u32(32'hFFFFFFFF); send_u32(32'hFFFFFFFF);
        send_byte(TAG_DOUBLE); send_u32(32'h80000000); send_u32(32'h00000001);
        send_byte(TAG_CLASS); send_u16(16'hFFFF);
        send_byte(TAG_STRING); send_u16(16'h0000);
        tb_pool_idx += 8;
        send_const(TAG_FIELDREF, 0);
        send_const(TAG_METHODREF, 0);
        send_const(TAG_IMETHODREF, 0);
        send_const(TAG_NAMETYPE, 0);
    endtask

    // random constants; a wide one takes the last index if only that is left
    task automatic test_pool_random();
        logic [7:0] tags [11];
        logic [7:0] t;
        tags = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
                 TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE};
        while (tb_pool_idx < POOL_SIZE - 1) begin
            t = tags[$urandom_range(0, 10)];
            send_const(t, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        if (tb_pool_idx == POOL_SIZE - 1)
            send_const($urandom_range(0, 1) ? TAG_LONG : TAG_DOUBLE, 0);
    endtask

    task automatic test_class_info();
        send_u16(16'hFFFF);
        send_u16(16'($urandom));
        send_u16(16'h0000);
        send_u16(16'd4);
        send_u16(16'hFFFF);
        send_u16(16'h0000);
        send_u16(16'($urandom));
        send_u16(16'($urandom));
    endtask

    task automatic test_fields();
        send_u16(16'd6);
        for (int i = 0; i < 6; i++) begin
            send_rand(6);
            send_attrs((i == 0) ? 0 : $urandom_range(1, 3), 12);
        end
    endtask

    task automatic test_methods();
        send_u16(16'd8);
        for (int i = 0; i < 8; i++) begin
            send_rand(6);
            send_attrs((i == 7) ? 0 : $urandom_range(1, 3), 30);
        end
    endtask

    // the class attributes end the file
    task automatic test_class_attrs();
        send_attrs(2, 10);
        send_byte(8'hFF);
        send_u16(16'd0);
        send_u32(32'd0);   // sent after the end of the file, so dropped
    endtask

    task automatic test_ignored_tail();
        send_rand(24);
    endtask

    // receiver: switches between free flow, random stalls and long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode <= 0;
            rx_hold <= 0;
        end else begin
            if (rx_hold == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_hold <= $urandom_range(20, 200);
            end else begin
                rx_hold <= rx_hold - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_rec got;
        t_rec want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.entry_index = m_axis_tdata[15:0];
            got.tag = m_axis_tdata[23:16];
            got.value_a = m_axis_tdata[87:24];
            got.value_b = m_axis_tdata[103:88];
            got.value_c = m_axis_tdata[119:104];
            got.scope = m_axis_tdata[121:120];
            got.final_record = m_axis_tlast;
            recs_seen++;
            if (pending_recs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected record kind %0d idx %0d a %h", $time,
                             got.kind, got.entry_index, got.value_a);
            end else begin
                want = pending_recs.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: record mismatch exp kind %0d idx %0d tag %0d a %h ",
                                  "b %h c %h sc %0d fin %0d / got kind %0d idx %0d tag %0d ",
                                  "a %h b %h c %h sc %0d fin %0d"}, $time,
                                 want.kind, want.entry_index, want.tag, want.value_a,
                                 want.value_b, want.value_c, want.scope, want.final_record,
                                 got.kind, got.entry_index, got.tag, got.value_a,
                                 got.value_b, got.value_c, got.scope, got.final_record);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d records outstanding", pending_recs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        prs_phase = PH_MAGIC; prs_count = 0; prs_shift = '0;
        prs_pool_idx = 16'd1; prs_pool_total = '0; prs_list_idx = '0; prs_list_total = '0;
        prs_attr_idx = '0; prs_attr_total = '0; prs_utf8_len = '0; prs_attr_name = '0;
        prs_left = '0; prs_tag = '0; prs_owner = SC_FIELD; prs_halted = 1'b0;
        fail_count = 0; bytes_sent = 0; recs_seen = 0; cycle_count = 0;
        burst_left = 0; tb_pool_idx = 1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header();
        test_pool_directed();
        test_pool_random();
        test_class_info();
        test_fields();
        test_methods();
        test_class_attrs();
        test_ignored_tail();
        s_axis_tvalid <= 1'b0;

        while (pending_recs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (pending_recs.size() != 0) fail_count++;
        $display("bytes sent %0d, records checked %0d: %0d-entry pool of every tag,",
                 bytes_sent, recs_seen, POOL_SIZE);
        $display("interfaces, fields, methods, class attributes and ignored trailing bytes");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> class_file_stream_parser_unit.f
hdl/cfsp_pkg.sv
hdl/cfsp_skid.sv
hdl/class_file_stream_parser_unit.sv
test/tb_top.sv
